// File: sv/kct_pkg.sv
// shared types, constants and helpers for the knob accelerated cursor tracker
package kct_pkg;

   localparam int unsigned MODE_W     = 2;
   localparam int unsigned INDEX_W    = 3;
   localparam int unsigned ENC_W      = 2;
   localparam int unsigned COUNT_W    = 16;
   localparam int unsigned POS_W      = 9;
   localparam int unsigned PRESET_W   = 10;
   localparam int unsigned DIV_CNT_W  = $clog2(PRESET_W + 1);
   localparam int unsigned STEP_W     = 6;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ATTACH = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SWAP   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam logic REG_HORIZ_LIMIT = 1'b0;
   localparam logic REG_VERT_LIMIT  = 1'b1;

   localparam logic [POS_W-1:0] HORIZ_LIMIT_RESET = 9'd240;
   localparam logic [POS_W-1:0] VERT_LIMIT_RESET  = 9'd300;

   localparam logic [ENC_W-1:0] ENC_NONE = 2'd0;

   localparam logic [COUNT_W-1:0] THRESH_FINE   = 16'd10;
   localparam logic [COUNT_W-1:0] THRESH_MEDIUM = 16'd100;

   localparam logic signed [STEP_W-1:0] STEP_NONE   = 6'sd0;
   localparam logic signed [STEP_W-1:0] STEP_FINE   = 6'sd1;
   localparam logic signed [STEP_W-1:0] STEP_MEDIUM = 6'sd5;
   localparam logic signed [STEP_W-1:0] STEP_COARSE = 6'sd20;

   localparam logic [PRESET_W-1:0] PRESET_MAX = 10'd1023;

   localparam logic [POS_W-1:0] POS_UPPER_A = 9'd150;
   localparam logic [POS_W-1:0] POS_UPPER_B = 9'd110;
   localparam logic [POS_W-1:0] POS_SIDE_A  = 9'd110;
   localparam logic [POS_W-1:0] POS_SIDE_B  = 9'd90;
   localparam logic [POS_W-1:0] POS_SIDE_C  = 9'd100;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [INDEX_W-1:0] cursor_index;
      logic [INDEX_W-1:0] second_index;
      logic [ENC_W-1:0]   encoder_id;
      logic [COUNT_W-1:0] counter_value;
   } req_payload_type;

   typedef struct packed {
      logic [POS_W-1:0]    position;
      logic [POS_W-1:0]    pos_x;
      logic [POS_W-1:0]    pos_y;
      logic                attached;
      logic                preset_valid;
      logic [ENC_W-1:0]    preset_encoder;
      logic [PRESET_W-1:0] preset_value;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SAMPLE_STEP,
      S_SAMPLE_MOVE,
      S_SWAP_LOOKUP,
      S_SWAP_PEER,
      S_ATTACH,
      S_DIVIDE,
      S_DETACH,
      S_REPORT
   } state_type;

   function automatic logic [POS_W-1:0] reset_position(int unsigned idx, int unsigned nv);
      int unsigned k;
      logic [POS_W-1:0] p;
      k = 0;
      if (idx < nv) begin
         p = (idx < 2) ? POS_UPPER_A : POS_UPPER_B;
      end else begin
         k = idx - nv;
         p = (k == 0) ? POS_SIDE_A : ((k == 1) ? POS_SIDE_B : POS_SIDE_C);
      end
      return p;
   endfunction

endpackage

// File: sv/kct_preset_div.sv
// serial restoring divider forming the counter preset position*1024/limit
module kct_preset_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [kct_pkg::POS_W-1:0]     pos,
   input  logic [kct_pkg::POS_W-1:0]     lim,
   output logic                          done,
   output logic [kct_pkg::PRESET_W-1:0]  quotient
);
   import kct_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [POS_W-1:0]     rem_ff, rem_in;
   logic [POS_W-1:0]     lim_ff, lim_in;
   logic [PRESET_W-1:0]  quo_ff, quo_in;
   logic [POS_W:0]       rem_dbl;
   logic                 fits;

   always_comb begin
      rem_dbl  = {rem_ff, 1'b0};
      fits     = rem_dbl >= {1'b0, lim_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      lim_in   = lim_ff;
      quo_in   = quo_ff;
      if (start) begin
         lim_in = lim;
         if (pos >= lim) begin
            quo_in  = PRESET_MAX;
            done_in = 1'b1;
         end else begin
            rem_in   = pos;
            quo_in   = '0;
            count_in = DIV_CNT_W'(PRESET_W);
            busy_in  = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in   = fits ? POS_W'(rem_dbl - {1'b0, lim_ff}) : rem_dbl[POS_W-1:0];
         quo_in   = {quo_ff[PRESET_W-2:0], fits};
         count_in = count_ff - DIV_CNT_W'(1);
         if (count_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      lim_ff   <= lim_in;
      quo_ff   <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: sv/knob_accelerated_cursor_tracker.sv
// Cursor tracker for knob-driven screen cursors. One item is taken at a time: req_ready is
// high only while the sequencer is idle. An attach or swap that emits a preset waits on the
// ten-step restoring divider that forms position*1024/limit. All cursor state sits in one
// register file read through a single index register, one entry per cycle. A finished result
// waits in an output register, and the next item is accepted meanwhile. Limits are written
// over the APB port at byte addresses 0 and 4.
module knob_accelerated_cursor_tracker #(
   parameter int unsigned NUM_CURSORS  = 6,
   parameter int unsigned NUM_VERTICAL = 3
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  kct_pkg::req_payload_type           req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output kct_pkg::rsp_payload_type           rsp_data,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [kct_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [kct_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [kct_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import kct_pkg::*;

   localparam int unsigned IDX_W = (NUM_CURSORS > 1) ? $clog2(NUM_CURSORS) : 1;

   state_type state_ff, state_in;

   logic [POS_W-1:0]   horiz_limit_ff, vert_limit_ff;
   logic [POS_W-1:0]   pos_ff  [NUM_CURSORS];
   logic [COUNT_W-1:0] last_ff [NUM_CURSORS];
   logic [ENC_W-1:0]   att_ff  [NUM_CURSORS];

   logic [IDX_W-1:0]          sel_ff, sel_in;
   logic [IDX_W-1:0]          c1_ff, c1_in;
   logic [IDX_W-1:0]          c2_ff, c2_in;
   logic [IDX_W-1:0]          det_ff, det_in;
   logic [IDX_W-1:0]          rep_ff, rep_in;
   logic                      has_det_ff, has_det_in;
   logic                      zero_ff, zero_in;
   logic [ENC_W-1:0]          enc_ff, enc_in;
   logic [COUNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [STEP_W-1:0]  step_ff, step_in;
   logic                      pend_valid_ff, pend_valid_in;
   logic [ENC_W-1:0]          pend_enc_ff, pend_enc_in;
   logic [PRESET_W-1:0]       pend_val_ff, pend_val_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_payload_type           rsp_data_ff, rsp_data_in;

   logic [POS_W-1:0]   rd_pos;
   logic [COUNT_W-1:0] rd_last;
   logic [ENC_W-1:0]   rd_att;
   logic               rd_vert;
   logic [POS_W-1:0]   rd_lim;

   logic               accept;
   logic               out_of_range;
   logic               rsp_free;
   logic               after_attach_det;

   logic [COUNT_W-1:0] diff;
   logic [COUNT_W-1:0] mag;
   logic signed [POS_W+1:0] pos_sum;
   logic [POS_W-1:0]   pos_clamped;

   logic               pos_wr, last_wr, att_wr;
   logic [POS_W-1:0]   pos_wr_val;
   logic [COUNT_W-1:0] last_wr_val;
   logic [ENC_W-1:0]   att_wr_val;

   logic               div_start, div_done;
   logic [PRESET_W-1:0] div_quo;

   logic               csr_write;

   kct_preset_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .pos      (rd_pos),
      .lim      (rd_lim),
      .done     (div_done),
      .quotient (div_quo)
   );

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[2])
         REG_HORIZ_LIMIT: csr_prdata = CSR_DATA_W'(horiz_limit_ff);
         REG_VERT_LIMIT:  csr_prdata = CSR_DATA_W'(vert_limit_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // single read port of the cursor register file
   always_comb begin
      rd_pos  = pos_ff[sel_ff];
      rd_last = last_ff[sel_ff];
      rd_att  = att_ff[sel_ff];
      rd_vert = (5'(sel_ff) < 5'(NUM_VERTICAL));
      rd_lim  = rd_vert ? vert_limit_ff : horiz_limit_ff;
      if (rd_lim == '0) begin
         rd_lim = POS_W'(1);
      end
   end

   assign req_ready    = (state_ff == S_IDLE);
   assign accept       = req_valid & req_ready;
   assign out_of_range = (5'(req_data.cursor_index) >= 5'(NUM_CURSORS)) ||
                         ((req_data.mode == MODE_SWAP) &&
                          (5'(req_data.second_index) >= 5'(NUM_CURSORS)));
   assign rsp_free     = ~rsp_valid_ff | rsp_ready;
   assign after_attach_det = has_det_ff;

   // sample arithmetic
   always_comb begin
      diff = cnt_ff - rd_last;
      mag  = diff[COUNT_W-1] ? (~diff + COUNT_W'(1)) : diff;
      pos_sum = $signed({2'b00, rd_pos}) + (POS_W+2)'(step_ff);
      if (pos_sum < 0) begin
         pos_clamped = '0;
      end else if (pos_sum >= $signed({2'b00, rd_lim})) begin
         pos_clamped = rd_lim - POS_W'(1);
      end else begin
         pos_clamped = pos_sum[POS_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (out_of_range) begin
                  state_in = S_REPORT;
               end else begin
                  unique case (req_data.mode)
                     MODE_SAMPLE: state_in = S_SAMPLE_STEP;
                     MODE_ATTACH: state_in = S_ATTACH;
                     MODE_SWAP:   state_in = S_SWAP_LOOKUP;
                     MODE_UNUSED: state_in = S_REPORT;
                     default:     state_in = S_REPORT;
                  endcase
               end
            end
         end
         S_SAMPLE_STEP: state_in = (rd_att == ENC_NONE) ? S_REPORT : S_SAMPLE_MOVE;
         S_SAMPLE_MOVE: state_in = S_REPORT;
         S_SWAP_LOOKUP: state_in = (rd_att != ENC_NONE) ? S_ATTACH : S_SWAP_PEER;
         S_SWAP_PEER:   state_in = S_ATTACH;
         S_ATTACH: begin
            if (rd_att == enc_ff || enc_ff == ENC_NONE) begin
               state_in = after_attach_det ? S_DETACH : S_REPORT;
            end else begin
               state_in = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            if (div_done) begin
               state_in = after_attach_det ? S_DETACH : S_REPORT;
            end
         end
         S_DETACH: state_in = S_REPORT;
         S_REPORT: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and register file control
   always_comb begin
      sel_in        = sel_ff;
      c1_in         = c1_ff;
      c2_in         = c2_ff;
      det_in        = det_ff;
      rep_in        = rep_ff;
      has_det_in    = has_det_ff;
      zero_in       = zero_ff;
      enc_in        = enc_ff;
      cnt_in        = cnt_ff;
      step_in       = step_ff;
      pend_valid_in = pend_valid_ff;
      pend_enc_in   = pend_enc_ff;
      pend_val_in   = pend_val_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_data_in   = rsp_data_ff;
      pos_wr        = 1'b0;
      last_wr       = 1'b0;
      att_wr        = 1'b0;
      pos_wr_val    = pos_clamped;
      last_wr_val   = cnt_ff;
      att_wr_val    = ENC_NONE;
      div_start     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               c1_in         = IDX_W'(req_data.cursor_index);
               c2_in         = IDX_W'(req_data.second_index);
               sel_in        = IDX_W'(req_data.cursor_index);
               rep_in        = IDX_W'(req_data.cursor_index);
               enc_in        = req_data.encoder_id;
               cnt_in        = req_data.counter_value;
               zero_in       = out_of_range;
               has_det_in    = 1'b0;
               pend_valid_in = 1'b0;
               pend_enc_in   = ENC_NONE;
               pend_val_in   = '0;
            end
         end
         S_SAMPLE_STEP: begin
            priority if (mag == '0) begin
               step_in = STEP_NONE;
            end else if (mag < THRESH_FINE) begin
               step_in = STEP_FINE;
            end else if (mag < THRESH_MEDIUM) begin
               step_in = STEP_MEDIUM;
            end else begin
               step_in = STEP_COARSE;
            end
            if (diff[COUNT_W-1]) begin
               step_in = -step_in;
            end
         end
         S_SAMPLE_MOVE: begin
            pos_wr  = 1'b1;
            last_wr = 1'b1;
         end
         S_SWAP_LOOKUP: begin
            has_det_in = 1'b1;
            sel_in     = c2_ff;
            if (rd_att != ENC_NONE) begin
               enc_in = rd_att;
               det_in = c1_ff;
               rep_in = c2_ff;
            end
         end
         S_SWAP_PEER: begin
            enc_in = rd_att;
            det_in = c2_ff;
            rep_in = c1_ff;
            sel_in = c1_ff;
         end
         S_ATTACH: begin
            if (rd_att == enc_ff || enc_ff == ENC_NONE) begin
               att_wr     = (rd_att != enc_ff);
               att_wr_val = ENC_NONE;
               sel_in     = after_attach_det ? det_ff : rep_ff;
            end else begin
               div_start = 1'b1;
            end
         end
         S_DIVIDE: begin
            if (div_done) begin
               att_wr        = 1'b1;
               att_wr_val    = enc_ff;
               last_wr       = 1'b1;
               last_wr_val   = COUNT_W'(div_quo);
               pend_valid_in = 1'b1;
               pend_enc_in   = enc_ff;
               pend_val_in   = div_quo;
               sel_in        = after_attach_det ? det_ff : rep_ff;
            end
         end
         S_DETACH: begin
            att_wr     = 1'b1;
            att_wr_val = ENC_NONE;
            sel_in     = rep_ff;
         end
         S_REPORT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (zero_ff) begin
                  rsp_data_in = '0;
               end else begin
                  rsp_data_in.position       = rd_pos;
                  rsp_data_in.pos_x          = rd_vert ? rd_pos : '0;
                  rsp_data_in.pos_y          = rd_vert ? '0 : rd_pos;
                  rsp_data_in.attached       = (rd_att != ENC_NONE);
                  rsp_data_in.preset_valid   = pend_valid_ff;
                  rsp_data_in.preset_encoder = pend_enc_ff;
                  rsp_data_in.preset_value   = pend_val_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         horiz_limit_ff <= HORIZ_LIMIT_RESET;
         vert_limit_ff  <= VERT_LIMIT_RESET;
         for (int i = 0; i < NUM_CURSORS; i++) begin
            pos_ff[i]  <= reset_position(i, NUM_VERTICAL);
            last_ff[i] <= '0;
            att_ff[i]  <= ENC_NONE;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_paddr[2])
               REG_HORIZ_LIMIT: horiz_limit_ff <= csr_pwdata[POS_W-1:0];
               REG_VERT_LIMIT:  vert_limit_ff  <= csr_pwdata[POS_W-1:0];
               default: begin
               end
            endcase
         end
         if (pos_wr) begin
            pos_ff[sel_ff] <= pos_wr_val;
         end
         if (last_wr) begin
            last_ff[sel_ff] <= last_wr_val;
         end
         if (att_wr) begin
            att_ff[sel_ff] <= att_wr_val;
         end
      end
      sel_ff        <= sel_in;
      c1_ff         <= c1_in;
      c2_ff         <= c2_in;
      det_ff        <= det_in;
      rep_ff        <= rep_in;
      has_det_ff    <= has_det_in;
      zero_ff       <= zero_in;
      enc_ff        <= enc_in;
      cnt_ff        <= cnt_in;
      step_ff       <= step_in;
      pend_valid_ff <= pend_valid_in;
      pend_enc_ff   <= pend_enc_in;
      pend_val_ff   <= pend_val_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: bench/tb.sv
// self-checking testbench for the knob accelerated cursor tracker
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import kct_pkg::*;

   localparam int unsigned N_CURSORS      = 6;
   localparam int unsigned N_VERTICAL     = 3;
   localparam int unsigned N_PHASES       = 6;
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned HOLD_AT        = 60;
   localparam int unsigned HOLD_CYCLES    = 300;
   localparam int unsigned TAIL_CYCLES    = 40;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_payload_type       req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // tracker state as predicted
   logic [POS_W-1:0]    cursor_pos[N_CURSORS];
   logic [COUNT_W-1:0]  last_cnt[N_CURSORS];
   logic [ENC_W-1:0]    enc_of[N_CURSORS];
   logic [POS_W-1:0]    horiz_lim;
   logic [POS_W-1:0]    vert_lim;
   logic                preset_hit;
   logic [ENC_W-1:0]    preset_enc;
   logic [PRESET_W-1:0] preset_val;

   logic [COUNT_W-1:0]  stim_count[N_CURSORS];
   req_payload_type     pending_items[$];
   rsp_payload_type     expected_reports[$];
   rsp_payload_type     oldest_report;

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;
   int unsigned mismatch_count = 0;
   int unsigned items_accepted = 0;
   int unsigned results_checked = 0;
   int unsigned presets_predicted = 0;
   int unsigned out_of_range_count = 0;
   int unsigned settings_count = 0;

   knob_accelerated_cursor_tracker #(
      .NUM_CURSORS  (N_CURSORS),
      .NUM_VERTICAL (N_VERTICAL)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int unsigned limit_for(int unsigned c);
      logic [POS_W-1:0] l;
      l = (c < N_VERTICAL) ? vert_lim : horiz_lim;
      return (l == '0) ? 1 : int'(l);
   endfunction

   function automatic void bind_encoder(int unsigned c, logic [ENC_W-1:0] enc);
      int unsigned p;
      if (enc_of[c] == enc) return;
      if (enc != ENC_NONE) begin
         p = (32'(cursor_pos[c]) * 32'd1024) / limit_for(c);
         if (p > PRESET_MAX) p = PRESET_MAX;
         enc_of[c] = enc;
         last_cnt[c] = COUNT_W'(p);
         preset_hit = 1'b1;
         preset_enc = enc;
         preset_val = PRESET_W'(p);
      end else begin
         enc_of[c] = ENC_NONE;
      end
   endfunction

   function automatic rsp_payload_type track_item(req_payload_type it);
      int unsigned c1, c2, rep, lim;
      logic [COUNT_W-1:0] diff;
      int delta, mag, stp, pos;
      logic [ENC_W-1:0] moved;
      rsp_payload_type r;
      r = '0;
      preset_hit = 1'b0;
      preset_enc = ENC_NONE;
      preset_val = '0;
      c1 = it.cursor_index;
      c2 = it.second_index;
      rep = c1;
      if (c1 >= N_CURSORS || (it.mode == MODE_SWAP && c2 >= N_CURSORS)) begin
         out_of_range_count++;
         return r;
      end
      case (it.mode)
         MODE_SAMPLE: begin
            if (enc_of[c1] != ENC_NONE) begin
               diff = it.counter_value - last_cnt[c1];
               delta = $signed(diff);
               mag = (delta < 0) ? -delta : delta;
               if (mag == 0) stp = STEP_NONE;
               else if (mag < int'(THRESH_FINE)) stp = STEP_FINE;
               else if (mag < int'(THRESH_MEDIUM)) stp = STEP_MEDIUM;
               else stp = STEP_COARSE;
               if (delta < 0) stp = -stp;
               last_cnt[c1] = it.counter_value;
               lim = limit_for(c1);
               pos = int'(cursor_pos[c1]) + stp;
               if (pos < 0) pos = 0;
               if (pos >= int'(lim)) pos = int'(lim) - 1;
               cursor_pos[c1] = POS_W'(pos);
            end
         end
         MODE_ATTACH: begin
            bind_encoder(c1, it.encoder_id);
         end
         MODE_SWAP: begin
            if (enc_of[c1] != ENC_NONE) begin
               moved = enc_of[c1];
               bind_encoder(c2, moved);
               bind_encoder(c1, ENC_NONE);
               rep = c2;
            end else begin
               moved = enc_of[c2];
               bind_encoder(c1, moved);
               bind_encoder(c2, ENC_NONE);
            end
         end
         default: begin
         end
      endcase
      r.position       = cursor_pos[rep];
      r.pos_x          = (rep < N_VERTICAL) ? cursor_pos[rep] : '0;
      r.pos_y          = (rep < N_VERTICAL) ? '0 : cursor_pos[rep];
      r.attached       = (enc_of[rep] != ENC_NONE);
      r.preset_valid   = preset_hit;
      r.preset_encoder = preset_enc;
      r.preset_value   = preset_val;
      if (preset_hit) presets_predicted++;
      return r;
   endfunction

   function automatic req_payload_type make_item(logic [MODE_W-1:0] mode, int unsigned c1,
                                                 int unsigned c2, int unsigned enc,
                                                 int unsigned cnt);
      req_payload_type it;
      it.mode          = mode;
      it.cursor_index  = INDEX_W'(c1);
      it.second_index  = INDEX_W'(c2);
      it.encoder_id    = ENC_W'(enc);
      it.counter_value = COUNT_W'(cnt);
      return it;
   endfunction

   function automatic req_payload_type random_item();
      logic [31:0] raw;
      req_payload_type it;
      int unsigned pick, c, mag;
      raw = $urandom;
      it = raw[$bits(req_payload_type)-1:0];
      pick = $urandom_range(99);
      c = $urandom_range(N_CURSORS - 1);
      if (pick < 93) it.cursor_index = INDEX_W'(c);
      if (pick < 55) begin
         it.mode = MODE_SAMPLE;
         case ($urandom_range(9))
            0: mag = 0;
            1, 2, 3: mag = $urandom_range(12, 1);
            4, 5, 6: mag = $urandom_range(110, 8);
            7, 8: mag = $urandom_range(40000, 90);
            default: mag = $urandom;
         endcase
         if ($urandom_range(1) == 1) stim_count[c] = stim_count[c] - COUNT_W'(mag);
         else stim_count[c] = stim_count[c] + COUNT_W'(mag);
         it.counter_value = stim_count[c];
      end else if (pick < 70) begin
         it.mode = MODE_ATTACH;
      end else if (pick < 82) begin
         it.mode = MODE_SWAP;
         it.second_index = INDEX_W'($urandom_range(N_CURSORS - 1));
      end else if (pick < 86) begin
         it.mode = MODE_UNUSED;
      end else if (pick < 93) begin
         if ($urandom_range(1) == 1) begin
            it.cursor_index = INDEX_W'($urandom_range(7, N_CURSORS));
         end else begin
            it.mode = MODE_SWAP;
            it.second_index = INDEX_W'($urandom_range(7, N_CURSORS));
         end
      end
      return it;
   endfunction

   task automatic compare_field(input string field, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   task automatic write_limit(input logic reg_sel, input logic [POS_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (reg_sel == REG_HORIZ_LIMIT) horiz_lim = value;
      else vert_lim = value;
      // read back in the following transfer
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      compare_field("limit read back", value, csr_prdata[POS_W-1:0]);
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      settings_count++;
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || req_valid || expected_reports.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_reports.push_back(track_item(req_data));
            items_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= pending_items.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %h", $time, rsp_data);
               mismatch_count++;
            end else begin
               oldest_report = expected_reports.pop_front();
               compare_field("position", oldest_report.position, rsp_data.position);
               compare_field("pos_x", oldest_report.pos_x, rsp_data.pos_x);
               compare_field("pos_y", oldest_report.pos_y, rsp_data.pos_y);
               compare_field("attached", oldest_report.attached, rsp_data.attached);
               compare_field("preset_valid", oldest_report.preset_valid,
                             rsp_data.preset_valid);
               compare_field("preset_encoder", oldest_report.preset_encoder,
                             rsp_data.preset_encoder);
               compare_field("preset_value", oldest_report.preset_value,
                             rsp_data.preset_value);
            end
            results_checked++;
            if (results_checked == HOLD_AT) hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned ph_horiz[N_PHASES];
      int unsigned ph_vert[N_PHASES];
      int unsigned ph_send[N_PHASES];
      int unsigned ph_recv[N_PHASES];
      int unsigned ph_items[N_PHASES];
      ph_horiz   = '{240, 511, 1, 0, 0, 17};
      ph_vert    = '{300, 511, 1, 0, 0, 400};
      ph_send    = '{0, 67, 0, 24, 24, 0};
      ph_recv    = '{0, 0, 67, 24, 24, 0};
      ph_items   = '{140, 130, 110, 90, 140, 140};
      cursor_pos = '{9'd150, 9'd150, 9'd110, 9'd110, 9'd90, 9'd100};
      last_cnt   = '{default: '0};
      enc_of     = '{default: ENC_NONE};
      stim_count = '{default: '0};
      horiz_lim  = HORIZ_LIMIT_RESET;
      vert_lim   = VERT_LIMIT_RESET;
      ph_horiz[4] = $urandom_range(510, 2);
      ph_vert[4]  = $urandom_range(510, 2);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int ph = 0; ph < N_PHASES; ph++) begin
         write_limit(REG_HORIZ_LIMIT, POS_W'(ph_horiz[ph]));
         write_limit(REG_VERT_LIMIT, POS_W'(ph_vert[ph]));
         @(negedge clock);
         send_idle_pct  = ph_send[ph];
         recv_stall_pct = ph_recv[ph];
         if (ph == 0) begin
            pending_items.push_back(make_item(MODE_SAMPLE, 0, 3, 2, 16'h1234));
            pending_items.push_back(make_item(MODE_ATTACH, 0, 0, 1, 0));
            pending_items.push_back(make_item(MODE_ATTACH, 0, 5, 1, 16'hffff));
            // preset of cursor 0 at reset limits is 512
            pending_items.push_back(make_item(MODE_SAMPLE, 0, 0, 0, 512));
            pending_items.push_back(make_item(MODE_SAMPLE, 0, 0, 3, 521));
            pending_items.push_back(make_item(MODE_SAMPLE, 0, 0, 0, 531));
            pending_items.push_back(make_item(MODE_SAMPLE, 0, 0, 0, 432));
            pending_items.push_back(make_item(MODE_SAMPLE, 0, 0, 0, 332));
            pending_items.push_back(make_item(MODE_SAMPLE, 0, 7, 0, 332 + 32768));
            pending_items.push_back(make_item(MODE_SAMPLE, 0, 0, 0, 16'hffff));
            pending_items.push_back(make_item(MODE_ATTACH, 3, 0, 2, 0));
            pending_items.push_back(make_item(MODE_ATTACH, 5, 0, 3, 0));
            pending_items.push_back(make_item(MODE_SWAP, 3, 4, 0, 0));
            pending_items.push_back(make_item(MODE_SWAP, 1, 4, 0, 0));
            pending_items.push_back(make_item(MODE_SWAP, 2, 2, 0, 0));
            pending_items.push_back(make_item(MODE_SWAP, 1, 1, 0, 0));
            pending_items.push_back(make_item(MODE_ATTACH, 5, 0, ENC_NONE, 0));
            pending_items.push_back(make_item(MODE_UNUSED, 2, 6, 3, 16'h8000));
            pending_items.push_back(make_item(MODE_SAMPLE, 6, 0, 1, 16'h00ff));
            pending_items.push_back(make_item(MODE_ATTACH, 7, 0, 1, 0));
            pending_items.push_back(make_item(MODE_SWAP, 0, 7, 0, 0));
            pending_items.push_back(make_item(MODE_UNUSED, 7, 7, 3, 16'hffff));
            pending_items.push_back(make_item(MODE_ATTACH, 2, 0, 3, 0));
            pending_items.push_back(make_item(MODE_ATTACH, 2, 0, 1, 0));
            pending_items.push_back(make_item(MODE_SAMPLE, 5, 0, 0, 0));
         end
         for (int n = 0; n < ph_items[ph]; n++) pending_items.push_back(random_item());
         wait_drained();
      end
      $display("covered %0d items and %0d results over %0d limit settings",
               items_accepted, results_checked, settings_count);
      $display("with %0d encoder presets and %0d out-of-range items",
               presets_predicted, out_of_range_count);
      if (mismatch_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/kct_pkg.sv
sv/kct_preset_div.sv
sv/knob_accelerated_cursor_tracker.sv
bench/tb.sv
